[hw/rtl/pese_pkg.sv]
// ---------------------------------------------------------------------------
// pese_pkg
// Shared types, constants and the microcode program of the prefix evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package pese_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;

  // Value reported for an empty stack
  localparam logic [7:0] EMPTY_VAL = 8'hFF;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OVER  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_ZNEG  = 3'd4;

  // Iteration counts of the shared arithmetic unit
  localparam logic [3:0] DIV_ITERS = 4'd8;
  localparam logic [3:0] POW_ITERS = 4'd7;

  typedef struct packed {
    logic       func;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] top_value;
    logic [2:0]        status;
    logic [4:0]        stack_depth;
  } out_item_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_IDLE,
    UOP_SIMPLE,
    UOP_POP_A,
    UOP_POP_B,
    UOP_PREP,
    UOP_ITER,
    UOP_FINAL,
    UOP_PUSH,
    UOP_EMIT
  } uop_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_IS_OPER,
    C_NO_ITER,
    C_ITER_MORE,
    C_OUT_BUSY
  } cond_t;

  localparam int PC_W = 4;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic is_oper;
    logic need_iter;
    logic iter_more;
  } dp_stat_t;

  // Program addresses
  localparam logic [PC_W-1:0] A_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] A_DECODE = 4'd1;
  localparam logic [PC_W-1:0] A_SIMPLE = 4'd2;
  localparam logic [PC_W-1:0] A_POP_A  = 4'd3;
  localparam logic [PC_W-1:0] A_SETTLE = 4'd4;
  localparam logic [PC_W-1:0] A_POP_B  = 4'd5;
  localparam logic [PC_W-1:0] A_PREP   = 4'd6;
  localparam logic [PC_W-1:0] A_ITER   = 4'd7;
  localparam logic [PC_W-1:0] A_FINAL  = 4'd8;
  localparam logic [PC_W-1:0] A_PUSH   = 4'd9;
  localparam logic [PC_W-1:0] A_EMIT   = 4'd10;
  localparam logic [PC_W-1:0] A_RETURN = 4'd11;

  // Control store: jump to target when the condition holds, else step on
  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] addr);
    ctl_word_t w;
    case (addr)
      A_IDLE:   w = '{UOP_IDLE,   C_NO_ITEM,   A_IDLE};
      A_DECODE: w = '{UOP_NOP,    C_IS_OPER,   A_POP_A};
      A_SIMPLE: w = '{UOP_SIMPLE, C_ALWAYS,    A_EMIT};
      A_POP_A:  w = '{UOP_POP_A,  C_NEVER,     A_IDLE};
      A_SETTLE: w = '{UOP_NOP,    C_NEVER,     A_IDLE};
      A_POP_B:  w = '{UOP_POP_B,  C_NEVER,     A_IDLE};
      A_PREP:   w = '{UOP_PREP,   C_NO_ITER,   A_FINAL};
      A_ITER:   w = '{UOP_ITER,   C_ITER_MORE, A_ITER};
      A_FINAL:  w = '{UOP_FINAL,  C_NEVER,     A_IDLE};
      A_PUSH:   w = '{UOP_PUSH,   C_NEVER,     A_IDLE};
      A_EMIT:   w = '{UOP_EMIT,   C_OUT_BUSY,  A_EMIT};
      A_RETURN: w = '{UOP_NOP,    C_ALWAYS,    A_IDLE};
      default:  w = '{UOP_NOP,    C_ALWAYS,    A_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pese_sequencer.sv]
// ---------------------------------------------------------------------------
// pese_sequencer
// Step counter over the control store with conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module pese_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire logic                 out_busy,
  input  wire pese_pkg::dp_stat_t   stat,
  output pese_pkg::ctl_word_t       ctl
);
  import pese_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctl = ucode_rom(pc);

  always_comb begin
    case (ctl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_ITEM:   take = !item_valid;
      C_IS_OPER:   take = stat.is_oper;
      C_NO_ITER:   take = !stat.need_iter;
      C_ITER_MORE: take = stat.iter_more;
      C_OUT_BUSY:  take = out_busy;
      default:     take = 1'b0;
    endcase
    pc_next = take ? ctl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pese_datapath.sv]
// ---------------------------------------------------------------------------
// pese_datapath
// Operand stack, operand registers and the shared divide / power unit.
// ---------------------------------------------------------------------------
`default_nettype none

module pese_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pese_pkg::uop_t       uop,
  input  wire logic                 start,
  input  wire pese_pkg::in_item_t   item,
  output pese_pkg::dp_stat_t        stat,
  output pese_pkg::out_item_t       res
);
  import pese_pkg::*;

  // Stack storage, read every cycle at the current top
  logic [7:0]       mem [STACK_DEPTH];
  logic [7:0]       rdata;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             wr_en;

  logic [CNT_W-1:0] count;
  logic             func;
  logic [7:0]       sym;

  logic [7:0] opa, opb;
  logic       under, divz, zneg;
  logic [7:0] rem, quo, dvsr;
  logic       neg;
  logic [7:0] acc, base;
  logic [6:0] expo;
  logic [3:0] iter_cnt;
  logic [7:0] res_val, res_top;
  logic [2:0] res_status;

  logic       empty, full, is_digit;
  logic       op_add, op_sub, op_mul, op_div, op_pow;
  logic [7:0] top_rd;
  logic [15:0] mul_ab, mul_acc, mul_base;
  logic [7:0] rem_sh;
  logic [8:0] trial;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign top_rd   = empty ? EMPTY_VAL : rdata;
  assign is_digit = !func && (sym >= CH_ZERO) && (sym <= CH_NINE);
  assign op_add   = !func && (sym == CH_PLUS);
  assign op_sub   = !func && (sym == CH_MINUS);
  assign op_mul   = !func && (sym == CH_STAR);
  assign op_div   = !func && (sym == CH_SLASH);
  assign op_pow   = !func && (sym == CH_CARET);

  assign stat.is_oper   = op_add || op_sub || op_mul || op_div || op_pow;
  assign stat.need_iter = (op_div && (opb != '0)) || (op_pow && !opb[7]);
  assign stat.iter_more = (iter_cnt > 4'd1);

  assign res.top_value   = res_top;
  assign res.status      = res_status;
  assign res.stack_depth = 5'(count);

  assign mul_ab   = {8'd0, opa} * {8'd0, opb};
  assign mul_acc  = {8'd0, acc} * {8'd0, base};
  assign mul_base = {8'd0, base} * {8'd0, base};

  // restoring divide step
  assign rem_sh = {rem[6:0], quo[7]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvsr};

  assign rd_addr = PTR_W'(count - CNT_W'(1));
  assign wr_addr = PTR_W'(count);
  assign wr_en   = ((uop == UOP_SIMPLE) && is_digit && !full) || (uop == UOP_PUSH);
  assign wr_data = (uop == UOP_PUSH) ? res_val : (sym - CH_ZERO);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      iter_cnt <= '0;
      under    <= 1'b0;
      divz     <= 1'b0;
      zneg     <= 1'b0;
    end else begin
      case (uop)
        UOP_IDLE: begin
          if (start) begin
            func  <= item.func;
            sym   <= item.symbol;
            under <= 1'b0;
            divz  <= 1'b0;
            zneg  <= 1'b0;
          end
        end
        UOP_SIMPLE: begin
          if (func) begin
            res_top    <= top_rd;
            res_status <= empty ? ST_UNDER : ST_OK;
            count      <= '0;
          end else if (is_digit && !full) begin
            res_top    <= sym - CH_ZERO;
            res_status <= ST_OK;
            count      <= count + CNT_W'(1);
          end else begin
            // full stack drops the digit; other characters change nothing
            res_top    <= top_rd;
            res_status <= is_digit ? ST_OVER : ST_OK;
          end
        end
        UOP_POP_A, UOP_POP_B: begin
          if (uop == UOP_POP_A) begin
            opa <= top_rd;
          end else begin
            opb <= top_rd;
          end
          if (empty) begin
            under <= 1'b1;
          end else begin
            count <= count - CNT_W'(1);
          end
        end
        UOP_PREP: begin
          iter_cnt <= '0;
          if (op_add) begin
            res_val <= opa + opb;
          end else if (op_sub) begin
            res_val <= opa - opb;
          end else if (op_mul) begin
            res_val <= mul_ab[7:0];
          end else if (op_div) begin
            if (opb == '0) begin
              divz    <= 1'b1;
              res_val <= '0;
            end else begin
              quo      <= opa[7] ? (8'd0 - opa) : opa;
              dvsr     <= opb[7] ? (8'd0 - opb) : opb;
              rem      <= '0;
              neg      <= opa[7] ^ opb[7];
              iter_cnt <= DIV_ITERS;
            end
          end else begin
            if (opb[7]) begin
              // negative exponent: truncated real result
              if (opa == 8'd0) begin
                zneg    <= 1'b1;
                res_val <= '0;
              end else if (opa == 8'd1) begin
                res_val <= 8'd1;
              end else if (opa == EMPTY_VAL) begin
                res_val <= opb[0] ? EMPTY_VAL : 8'd1;
              end else begin
                res_val <= '0;
              end
            end else begin
              acc      <= 8'd1;
              base     <= opa;
              expo     <= opb[6:0];
              iter_cnt <= POW_ITERS;
            end
          end
        end
        UOP_ITER: begin
          iter_cnt <= iter_cnt - 4'd1;
          if (op_div) begin
            if (!trial[8]) begin
              rem <= trial[7:0];
              quo <= {quo[6:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[6:0], 1'b0};
            end
          end else begin
            if (expo[0]) begin
              acc <= mul_acc[7:0];
            end
            base <= mul_base[7:0];
            expo <= {1'b0, expo[6:1]};
          end
        end
        UOP_FINAL: begin
          if (op_div && (opb != '0)) begin
            res_val <= neg ? (8'd0 - quo) : quo;
          end else if (op_pow && !opb[7]) begin
            res_val <= acc;
          end
        end
        UOP_PUSH: begin
          count   <= count + CNT_W'(1);
          res_top <= res_val;
          if (under) begin
            res_status <= ST_UNDER;
          end else if (divz) begin
            res_status <= ST_DIVZ;
          end else if (zneg) begin
            res_status <= ST_ZNEG;
          end else begin
            res_status <= ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (uop == UOP_PUSH) |-> (count < CNT_W'(STACK_DEPTH)))
    else $error("operator push without room");

  a_iter_live: assert property (@(posedge clk) disable iff (rst)
    (uop == UOP_ITER) |-> (iter_cnt != '0))
    else $error("iteration step with spent counter");
`endif

endmodule

`default_nettype wire

[hw/rtl/prefix_expression_stack_evaluator.sv]
// ---------------------------------------------------------------------------
// prefix_expression_stack_evaluator
// Evaluates a reversed prefix expression one character item at a time.
// ---------------------------------------------------------------------------
// Result path: digits, finish and other characters take the simple step;
//   + - *, divide by zero and ^ with exponent < 0 skip the loop; ^ with
//   exponent >= 0 runs 7 loop steps, and / otherwise runs 8 loop steps.
// Input: a new item is taken only after the last result is loaded; a held result delays that.
// Reset (rst, synchronous): stack empty, sequencer at its idle word,
//   no result pending. Stack contents are not cleared.
`default_nettype none

module prefix_expression_stack_evaluator (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire pese_pkg::in_item_t   item,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output pese_pkg::out_item_t       result
);
  import pese_pkg::*;

  ctl_word_t ctl;
  dp_stat_t  stat;
  out_item_t res_now;
  logic      out_busy;
  logic      start;
  logic      load;

  // Input is taken only at the idle word of the program.
  assign item_ready = (ctl.uop == UOP_IDLE);
  assign start      = item_ready && item_valid;

  // Result register decouples the sink; the emit word waits while it is full and not taken.
  assign out_busy = result_valid && !result_ready;
  assign load     = (ctl.uop == UOP_EMIT) && !out_busy;

  pese_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .out_busy   (out_busy),
    .stat       (stat),
    .ctl        (ctl)
  );

  pese_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .uop   (ctl.uop),
    .start (start),
    .item  (item),
    .stat  (stat),
    .res   (res_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_now;
    end
  end

`ifndef NO_ASSERTIONS
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("sequencer stayed idle after taking an item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!result_valid || result_ready))
    else $error("result register overwritten while held");

  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    load |=> (ctl.uop != UOP_EMIT))
    else $error("emit word repeated after loading a result");
`endif

endmodule

`default_nettype wire
